@@ rtl/core/avrdec_pkg.sv @@
// Shared types and class codes for the AVR instruction decoder.
`timescale 1ns / 1ps

package avrdec_pkg;

	// Word handed on for the implied-r0 program-memory loads
	localparam logic [15:0] LPM_GENERAL  = 16'h9004;
	localparam logic [15:0] ELPM_GENERAL = 16'h9006;

	// Instruction classes, numbered in handler order
	typedef enum logic [6:0] {
		CLS_NOP     = 7'd0,
		CLS_MOVW    = 7'd1,
		CLS_MULS    = 7'd2,
		CLS_MULSU   = 7'd3,
		CLS_FMUL    = 7'd4,
		CLS_FMULS   = 7'd5,
		CLS_FMULSU  = 7'd6,
		CLS_CPC     = 7'd7,
		CLS_CP      = 7'd8,
		CLS_SBC     = 7'd9,
		CLS_SUB     = 7'd10,
		CLS_ADC     = 7'd11,
		CLS_ADD     = 7'd12,
		CLS_CPSE    = 7'd13,
		CLS_AND     = 7'd14,
		CLS_EOR     = 7'd15,
		CLS_OR      = 7'd16,
		CLS_MOV     = 7'd17,
		CLS_CPI     = 7'd18,
		CLS_SBCI    = 7'd19,
		CLS_SUBI    = 7'd20,
		CLS_ORI     = 7'd21,
		CLS_ANDI    = 7'd22,
		CLS_STD     = 7'd23,
		CLS_LDD     = 7'd24,
		CLS_STS     = 7'd25,
		CLS_ST_Y    = 7'd26,
		CLS_ST_Z    = 7'd27,
		CLS_PUSH    = 7'd28,
		CLS_ST_X    = 7'd29,
		CLS_LDS     = 7'd30,
		CLS_LD_Y    = 7'd31,
		CLS_LD_Z    = 7'd32,
		CLS_POP     = 7'd33,
		CLS_LD_X    = 7'd34,
		CLS_LPM     = 7'd35,
		CLS_ELPM    = 7'd36,
		CLS_COM     = 7'd37,
		CLS_NEG     = 7'd38,
		CLS_SWAP    = 7'd39,
		CLS_INC     = 7'd40,
		CLS_ASR     = 7'd41,
		CLS_LSR     = 7'd42,
		CLS_ROR     = 7'd43,
		CLS_RET     = 7'd44,
		CLS_RETI    = 7'd45,
		CLS_SLEEP   = 7'd46,
		CLS_SPM     = 7'd47,
		CLS_BCLR    = 7'd48,
		CLS_BSET    = 7'd49,
		CLS_ICALL   = 7'd50,
		CLS_IJMP    = 7'd51,
		CLS_EICALL  = 7'd52,
		CLS_EIJMP   = 7'd53,
		CLS_DEC     = 7'd54,
		CLS_JMP     = 7'd55,
		CLS_CALL    = 7'd56,
		CLS_ADIW    = 7'd57,
		CLS_SBIW    = 7'd58,
		CLS_SBI     = 7'd59,
		CLS_CBI     = 7'd60,
		CLS_SBIS    = 7'd61,
		CLS_SBIC    = 7'd62,
		CLS_MUL     = 7'd63,
		CLS_IN      = 7'd64,
		CLS_OUT     = 7'd65,
		CLS_RJMP    = 7'd66,
		CLS_RCALL   = 7'd67,
		CLS_LDI     = 7'd68,
		CLS_BRANCH  = 7'd69,
		CLS_BLD     = 7'd70,
		CLS_BST     = 7'd71,
		CLS_SBRS    = 7'd72,
		CLS_SBRC    = 7'd73,
		CLS_INVALID = 7'd74
	} class_t;

	// One decoded instruction
	typedef struct packed {
		class_t      cls;
		logic [15:0] word;
		logic        invalid;
	} dec_result_t;

endpackage

@@ rtl/core/avrdec_classify.sv @@
// Combinational classifier: instruction word to class and handed word.
`timescale 1ns / 1ps

module avrdec_classify (
	input  logic [15:0]              word,
	output avrdec_pkg::dec_result_t  result
);
	import avrdec_pkg::*;

	logic [7:0] hi;
	logic [7:0] lo;
	logic [3:0] n;
	class_t     cls;
	logic [15:0] handed;

	assign hi = word[15:8];
	assign lo = word[7:0];
	assign n  = word[3:0];

	// Class selection by opcode group
	always_comb begin
		cls    = CLS_INVALID;
		handed = word;
		if (hi[7:2] == 6'b000000) begin
			// nop, movw, multiply forms
			unique case (hi[1:0])
				2'd0: cls = (lo == 8'h00) ? CLS_NOP : CLS_INVALID;
				2'd1: cls = CLS_MOVW;
				2'd2: cls = CLS_MULS;
				default: begin
					unique case ({lo[7], lo[3]})
						2'b00: cls = CLS_MULSU;
						2'b01: cls = CLS_FMUL;
						2'b10: cls = CLS_FMULS;
						default: cls = CLS_FMULSU;
					endcase
				end
			endcase
		end else if (hi[7:6] == 2'b00) begin
			// two-register ALU and cpi
			unique case (hi[5:2])
				4'h1: cls = CLS_CPC;
				4'h5: cls = CLS_CP;
				4'h2: cls = CLS_SBC;
				4'h6: cls = CLS_SUB;
				4'h7: cls = CLS_ADC;
				4'h3: cls = CLS_ADD;
				4'h4: cls = CLS_CPSE;
				4'h8: cls = CLS_AND;
				4'h9: cls = CLS_EOR;
				4'ha: cls = CLS_OR;
				4'hb: cls = CLS_MOV;
				default: cls = (hi[5:4] == 2'b11) ? CLS_CPI : CLS_INVALID;
			endcase
		end else if (hi[7:6] == 2'b01) begin
			// immediate ALU
			unique case (hi[5:4])
				2'd0: cls = CLS_SBCI;
				2'd1: cls = CLS_SUBI;
				2'd2: cls = CLS_ORI;
				default: cls = CLS_ANDI;
			endcase
		end else if ((hi & 8'hd0) == 8'h80) begin
			// displacement load/store
			cls = hi[1] ? CLS_STD : CLS_LDD;
		end else if (hi[7:2] == 6'b100100) begin
			// pointer load/store, push/pop, lpm/elpm
			if (hi[1]) begin
				if (n == 4'h0)             cls = CLS_STS;
				else if (n[3:2] == 2'b10)  cls = CLS_ST_Y;
				else if (n[3:2] == 2'b00)  cls = CLS_ST_Z;
				else if (n == 4'hf)        cls = CLS_PUSH;
				else if (n[3:2] == 2'b11)  cls = CLS_ST_X;
				else                       cls = CLS_INVALID;
			end else begin
				if (n == 4'h0)             cls = CLS_LDS;
				else if (n[3:2] == 2'b10)  cls = CLS_LD_Y;
				else if (n[3:2] == 2'b00)  cls = CLS_LD_Z;
				else if (n == 4'hf)        cls = CLS_POP;
				else if (n[3:2] == 2'b11)  cls = CLS_LD_X;
				else if (n[3:1] == 3'b010) cls = CLS_LPM;
				else                       cls = CLS_ELPM;
			end
		end else if (hi[7:1] == 7'b1001010) begin
			// single-operand and control group
			if (!lo[3]) begin
				unique case (n[2:0])
					3'd0: cls = CLS_COM;
					3'd1: cls = CLS_NEG;
					3'd2: cls = CLS_SWAP;
					3'd3: cls = CLS_INC;
					3'd4: cls = CLS_INVALID;
					3'd5: cls = CLS_ASR;
					3'd6: cls = CLS_LSR;
					default: cls = CLS_ROR;
				endcase
			end else if (hi == 8'h95 && n == 4'h8) begin
				if (lo == 8'h08)      cls = CLS_RET;
				else if (lo == 8'h18) cls = CLS_RETI;
				else if (lo == 8'h88) cls = CLS_SLEEP;
				else if (lo == 8'hc8) begin
					cls    = CLS_LPM;
					handed = LPM_GENERAL;
				end else if (lo == 8'hd8) begin
					cls    = CLS_ELPM;
					handed = ELPM_GENERAL;
				end else if ((lo & 8'hef) == 8'he8) cls = CLS_SPM;
				else cls = CLS_INVALID;
			end else if (!hi[0] && n == 4'h8) begin
				cls = lo[7] ? CLS_BCLR : CLS_BSET;
			end else if (lo == 8'h09) begin
				cls = hi[0] ? CLS_ICALL : CLS_IJMP;
			end else if (lo == 8'h19) begin
				cls = hi[0] ? CLS_EICALL : CLS_EIJMP;
			end else if (n == 4'ha) begin
				cls = CLS_DEC;
			end else if (n[3:1] == 3'b110) begin
				cls = CLS_JMP;
			end else if (n[3:1] == 3'b111) begin
				cls = CLS_CALL;
			end else begin
				cls = CLS_INVALID;
			end
		end else if (hi[7:4] == 4'h9) begin
			// word immediates, I/O bit ops, mul
			unique case (hi[3:0])
				4'h6: cls = CLS_ADIW;
				4'h7: cls = CLS_SBIW;
				4'ha: cls = CLS_SBI;
				4'h8: cls = CLS_CBI;
				4'hb: cls = CLS_SBIS;
				4'h9: cls = CLS_SBIC;
				default: cls = CLS_MUL;
			endcase
		end else if (hi[7:3] == 5'b10110) cls = CLS_IN;
		else if (hi[7:3] == 5'b10111)     cls = CLS_OUT;
		else if (hi[7:4] == 4'hc)         cls = CLS_RJMP;
		else if (hi[7:4] == 4'hd)         cls = CLS_RCALL;
		else if (hi[7:4] == 4'he)         cls = CLS_LDI;
		else if (hi[7:3] == 5'b11110)     cls = CLS_BRANCH;
		else if (hi[7:1] == 7'b1111100)   cls = CLS_BLD;
		else if (hi[7:1] == 7'b1111101)   cls = CLS_BST;
		else if (hi[7:1] == 7'b1111111)   cls = CLS_SBRS;
		else if (hi[7:1] == 7'b1111110)   cls = CLS_SBRC;
		else                              cls = CLS_INVALID;
	end

	assign result.cls     = cls;
	assign result.word    = handed;
	assign result.invalid = (cls == CLS_INVALID);

endmodule

@@ rtl/core/avr_instruction_decoder.sv @@
// Top level of the AVR instruction decoder: input and result registers.
`timescale 1ns / 1ps

// AVR instruction decoder. A request (start high, busy low) carries one
// 16-bit instruction word as two bytes; it passes the input register and
// the result register, then done pulses for one cycle with the instruction
// class, the word handed to the executor and the invalid flag. busy never
// rises, so a new word may be given every cycle and one result leaves every
// cycle. Results cannot be held off, so the receiver must take each one in
// the cycle that done is high. Encodings the executor does not support come
// out as class 74 with invalid set; the implied-r0 lpm and elpm words are
// handed on as 0x9004 and 0x9006.
module avr_instruction_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  word_low,
	input  logic [7:0]  word_high,
	output logic        done,
	output logic [6:0]  class_code,
	output logic [15:0] handed_word,
	output logic        invalid
);
	import avrdec_pkg::*;

	logic        valid_s1;
	logic [15:0] word_s1;
	logic        valid_s2;
	dec_result_t dec_res;
	dec_result_t result_s2;

	assign busy = 1'b0;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			word_s1 <= {word_high, word_low};
		end
	end

	// Decode
	avrdec_classify u_classify (
		.word   (word_s1),
		.result (dec_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= dec_res;
		end
	end

	assign done        = valid_s2;
	assign class_code  = result_s2.cls;
	assign handed_word = result_s2.word;
	assign invalid     = result_s2.invalid;

`ifndef ASSERT_OFF
	// Every request yields a result through the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("request did not produce a result");

	// A result only follows a request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("result without a request");

	// Invalid flag agrees with the class
	a_invalid_class: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (invalid == (class_code == CLS_INVALID)))
		else $error("invalid flag and class disagree");

	// Apart from lpm and elpm, the word travels with its class through both stages
	a_word_path: assert property (@(posedge clk) disable iff (!arst_n)
		done && (class_code != CLS_LPM) && (class_code != CLS_ELPM)
		|-> handed_word == {$past(word_high, 2), $past(word_low, 2)})
		else $error("handed word does not match the request");
`endif

endmodule
